>>> rtl/uvs_pkg.sv
// Shared types, constants and the CORDIC angle table for the UV sphere vertex generator.
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int COUNT_BITS = 8;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int RADIUS_BITS = 16;
  localparam int TEX_BITS = 17;
  localparam int TEX_T_FRAC = 16;
  localparam int TEX_S_FRAC = 15;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 16'd256;
  localparam logic [COUNT_BITS-1:0] COUNT_RST = COUNT_BITS'(16);
  localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(4);
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic [1:0] LAST_VERTEX = 2'd2;

  typedef enum logic [1:0] {
    REG_RADIUS,
    REG_SLICES,
    REG_STACKS
  } reg_idx_t;

  typedef enum logic [1:0] {
    CAP_SOUTH,
    CAP_NORTH,
    CAP_BAND
  } cap_t;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FEED_LAT,
    ST_FEED_LNG,
    ST_CORDIC,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic               valid;
    logic               lng;
    quad_t              quad;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } beat_t;

  function automatic logic signed [31:0] atan_angle(input int idx);
    case (idx)
      0:  return 32'sd536870912;
      1:  return 32'sd316933406;
      2:  return 32'sd167458907;
      3:  return 32'sd85004756;
      4:  return 32'sd42667331;
      5:  return 32'sd21354465;
      6:  return 32'sd10679838;
      7:  return 32'sd5340245;
      8:  return 32'sd2670163;
      9:  return 32'sd1335087;
      10: return 32'sd667544;
      11: return 32'sd333772;
      12: return 32'sd166886;
      13: return 32'sd83443;
      14: return 32'sd41722;
      15: return 32'sd20861;
      16: return 32'sd10430;
      17: return 32'sd5215;
      18: return 32'sd2608;
      19: return 32'sd1304;
      20: return 32'sd652;
      21: return 32'sd326;
      22: return 32'sd163;
      23: return 32'sd81;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

>>> rtl/uvs_divider.sv
// Restoring divider: quot = floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
`timescale 1ns / 1ps
module uvs_divider #(
  parameter int NUM_BITS = uvs_pkg::COUNT_BITS + 1,
  parameter int DEN_BITS = uvs_pkg::COUNT_BITS,
  parameter int FRAC_BITS = uvs_pkg::TEX_T_FRAC
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_BITS-1:0]   num,
  input  logic [DEN_BITS-1:0]   den,
  output logic                  busy,
  output logic [FRAC_BITS+1:0]  quot
);
  localparam int DivBits = NUM_BITS + FRAC_BITS;
  localparam int QuotBits = FRAC_BITS + 2;
  localparam int CntBits = $clog2(DivBits + 1);

  logic [DivBits-1:0]  dividend;
  logic [DEN_BITS-1:0] rem;
  logic [CntBits-1:0]  count;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  assign trial = {rem, dividend[DivBits-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CntBits'(DivBits);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {num, {FRAC_BITS{1'b0}}};
      rem <= '0;
      quot <= '0;
    end else if (busy) begin
      dividend <= dividend << 1;
      rem <= fits ? DEN_BITS'(trial - {1'b0, den}) : trial[DEN_BITS-1:0];
      quot <= {quot[QuotBits-2:0], fits};
    end
  end

endmodule

>>> rtl/uvs_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine chain.
`timescale 1ns / 1ps
module uvs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  uvs_pkg::beat_t beat_in,
  output uvs_pkg::beat_t beat_out
);
  import uvs_pkg::*;

  localparam logic signed [31:0] Atan = atan_angle(STEP);

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] zs;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  assign xs = beat_in.x;
  assign ys = beat_in.y;
  assign zs = beat_in.z;
  assign dx = ys >>> STEP;
  assign dy = xs >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_out.lng <= beat_in.lng;
    beat_out.quad <= beat_in.quad;
    if (!zs[31]) begin
      beat_out.x <= xs - dx;
      beat_out.y <= ys + dy;
      beat_out.z <= zs - Atan;
    end else begin
      beat_out.x <= xs + dx;
      beat_out.y <= ys - dy;
      beat_out.z <= zs + Atan;
    end
  end

endmodule

>>> rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: triangle sequencer, dividers, CORDIC chain, math.
//
// channel  | handshake                  | payload
// item     | item_valid / item_stall    | restart
// vertex   | vertex_valid / vertex_stall| pos_x..z, norm_x..z, tex_s, tex_t, triangle_end, sphere_end
// config   | wr_en                      | wr_index, wr_data
//
// A triangle takes an accept and three vertex passes. Each pass runs a divider start, the
// division, a done check, a latitude feed and a longitude feed into the CORDIC chain, a wait
// until the longitude beat leaves the chain, the product states ST_MUL1 and ST_MUL2 and a load.
// A restart beat emits nothing. Reset returns to the first triangle.
// A stalled vertex holds the last pass; the next item is taken once the third vertex is loaded.
`timescale 1ns / 1ps
module uv_sphere_vertex_generator #(
  parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = uvs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               restart,
  output logic                               vertex_valid,
  input  logic                               vertex_stall,
  output logic signed [23:0]                 pos_x,
  output logic signed [23:0]                 pos_y,
  output logic signed [23:0]                 pos_z,
  output logic signed [15:0]                 norm_x,
  output logic signed [15:0]                 norm_y,
  output logic signed [15:0]                 norm_z,
  output logic [uvs_pkg::TEX_BITS-1:0]       tex_s,
  output logic [uvs_pkg::TEX_BITS-1:0]       tex_t,
  output logic                               triangle_end,
  output logic                               sphere_end,
  input  logic                               wr_en,
  input  logic [1:0]                         wr_index,
  input  logic [uvs_pkg::RADIUS_BITS-1:0]    wr_data
);
  import uvs_pkg::*;

  localparam int DivFrac = (ANGLE_BITS - 1 > TEX_T_FRAC) ? ANGLE_BITS - 1 : TEX_T_FRAC;
  localparam int QuotBits = DivFrac + 2;
  localparam int KBits = COUNT_BITS + 1;
  localparam logic [ANGLE_BITS-1:0] LatOffset = {2'b11, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] LngOffset = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  function automatic logic signed [23:0] sat_pos(input logic signed [48:0] p);
    logic signed [48:0] r;
    r = (p + 49'sd4194304) >>> 23;
    if (r > 49'sd8388607) return 24'sh7FFFFF;
    if (r < -49'sd8388608) return 24'sh800000;
    return r[23:0];
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [31:0] u);
    logic signed [32:0] r;
    r = ($signed({u[31], u}) + 33'sd16384) >>> 15;
    if (r > 33'sd32767) return 16'sh7FFF;
    if (r < -33'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // configuration and sequence state
  logic [RADIUS_BITS-1:0] radius;
  logic [COUNT_BITS-1:0]  slice_count;
  logic [COUNT_BITS-1:0]  stack_count;
  logic [COUNT_BITS-1:0]  stack_position;
  logic [COUNT_BITS-1:0]  slice_position;
  logic                   band_second_half;
  cap_t                   cap_phase;
  logic [COUNT_BITS-1:0]  stack_position_next;
  logic [COUNT_BITS-1:0]  slice_position_next;
  logic                   band_second_half_next;
  cap_t                   cap_phase_next;

  state_t state;
  state_t state_next;
  logic [1:0] vidx;

  logic [COUNT_BITS-1:0] slices;
  logic [COUNT_BITS-1:0] stacks;
  logic [COUNT_BITS-1:0] stacks_m1;
  logic                  start_over;
  cap_t                  ph;
  logic [COUNT_BITS-1:0] si;
  logic [COUNT_BITS-1:0] sb;
  logic                  sh;
  logic [COUNT_BITS-1:0] si_inc;
  logic [COUNT_BITS-1:0] sb_inc;
  logic [KBits-1:0]      k0;
  logic                  tri_last;
  logic [COUNT_BITS-1:0] j_tri [0:2];
  logic [KBits-1:0]      k_tri [0:2];
  logic [COUNT_BITS-1:0] j_list [0:2];
  logic [KBits-1:0]      k_list [0:2];
  logic                  sphere_last;

  logic accept;
  logic div_start;
  logic feed_valid;
  logic feed_lng;
  logic load;
  logic out_free;

  logic                busy_j;
  logic                busy_k;
  logic [QuotBits-1:0] quot_j;
  logic [QuotBits-1:0] quot_k;
  logic [ANGLE_BITS-1:0] lat_ang;
  logic [ANGLE_BITS-1:0] lng_ang;
  logic [ANGLE_BITS-1:0] ang;
  logic [31:0]           a32;

  beat_t chain [0:CORDIC_STEPS];
  beat_t tail;
  logic signed [31:0] c_map;
  logic signed [31:0] s_map;
  logic signed [31:0] c_lat;
  logic signed [31:0] s_lat;
  logic signed [31:0] c_lng;
  logic signed [31:0] s_lng;
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_z;
  logic signed [31:0] ux;
  logic signed [31:0] uy;
  logic signed [31:0] uz;
  logic signed [16:0] rad_s;
  logic signed [48:0] px;
  logic signed [48:0] py;
  logic signed [48:0] pz;

  assign slices = (slice_count < MIN_COUNT) ? MIN_COUNT : slice_count;
  assign stacks = (stack_count < MIN_COUNT) ? MIN_COUNT : stack_count;
  assign stacks_m1 = stacks - 1'b1;

  assign item_stall = (state != ST_IDLE);
  assign accept = item_valid && !item_stall;
  assign out_free = !vertex_valid || !vertex_stall;

  // sequence: triangle vertices and the position after it
  always_comb begin
    case (cap_phase)
      CAP_SOUTH, CAP_NORTH: start_over = (slice_position >= slices);
      CAP_BAND: start_over = (slice_position >= slices) || (stack_position == '0)
                             || (stack_position >= stacks_m1);
      default: start_over = 1'b1;
    endcase
    ph = start_over ? CAP_SOUTH : cap_phase;
    si = start_over ? '0 : slice_position;
    sb = start_over ? '0 : stack_position;
    sh = start_over ? 1'b0 : band_second_half;
    si_inc = si + 1'b1;
    sb_inc = sb + 1'b1;
    k0 = {si, 1'b0};
    tri_last = 1'b0;
    stack_position_next = sb;
    slice_position_next = si;
    band_second_half_next = sh;
    cap_phase_next = ph;
    case (ph)
      CAP_SOUTH: begin
        j_tri[0] = '0;                   k_tri[0] = k0 + KBits'(1);
        j_tri[1] = COUNT_BITS'(1);       k_tri[1] = k0 + KBits'(2);
        j_tri[2] = COUNT_BITS'(1);       k_tri[2] = k0;
      end
      CAP_NORTH: begin
        j_tri[0] = stacks;               k_tri[0] = k0 + KBits'(1);
        j_tri[1] = stacks_m1;            k_tri[1] = k0;
        j_tri[2] = stacks_m1;            k_tri[2] = k0 + KBits'(2);
      end
      default: begin
        if (!sh) begin
          j_tri[0] = sb_inc;             k_tri[0] = k0;
          j_tri[1] = sb;                 k_tri[1] = k0;
          j_tri[2] = sb_inc;             k_tri[2] = k0 + KBits'(2);
        end else begin
          j_tri[0] = sb_inc;             k_tri[0] = k0 + KBits'(2);
          j_tri[1] = sb;                 k_tri[1] = k0;
          j_tri[2] = sb;                 k_tri[2] = k0 + KBits'(2);
          tri_last = ({1'b0, si} + 1'b1 >= {1'b0, slices})
                     && ({1'b0, sb} + 1'b1 >= {1'b0, stacks_m1});
        end
      end
    endcase
    if (ph != CAP_BAND) begin
      slice_position_next = si_inc;
      if (si_inc == '0 || si_inc >= slices) begin
        slice_position_next = '0;
        if (ph == CAP_SOUTH) begin
          cap_phase_next = CAP_NORTH;
        end else begin
          cap_phase_next = CAP_BAND;
          stack_position_next = COUNT_BITS'(1);
          band_second_half_next = 1'b0;
        end
      end
    end else if (!sh) begin
      band_second_half_next = 1'b1;
    end else begin
      band_second_half_next = 1'b0;
      slice_position_next = si_inc;
      if (si_inc == '0 || si_inc >= slices) begin
        slice_position_next = '0;
        stack_position_next = sb_inc;
        if (sb_inc == '0 || sb_inc >= stacks_m1) begin
          stack_position_next = '0;
          cap_phase_next = CAP_SOUTH;
        end
      end
    end
    if (restart) begin
      stack_position_next = '0;
      slice_position_next = '0;
      band_second_half_next = 1'b0;
      cap_phase_next = CAP_SOUTH;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    feed_valid = 1'b0;
    feed_lng = 1'b0;
    load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid && !restart) state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!busy_j && !busy_k) state_next = ST_FEED_LAT;
      end
      ST_FEED_LAT: begin
        feed_valid = 1'b1;
        state_next = ST_FEED_LNG;
      end
      ST_FEED_LNG: begin
        feed_valid = 1'b1;
        feed_lng = 1'b1;
        state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (tail.valid && tail.lng) state_next = ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          state_next = (vidx == LAST_VERTEX) ? ST_IDLE : ST_DIV_GO;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vidx <= '0;
      vertex_valid <= 1'b0;
      radius <= RADIUS_RST;
      slice_count <= COUNT_RST;
      stack_count <= COUNT_RST;
      stack_position <= '0;
      slice_position <= '0;
      band_second_half <= 1'b0;
      cap_phase <= CAP_SOUTH;
    end else begin
      state <= state_next;
      if (wr_en) begin
        case (reg_idx_t'(wr_index))
          REG_RADIUS: radius <= wr_data;
          REG_SLICES: slice_count <= wr_data[COUNT_BITS-1:0];
          REG_STACKS: stack_count <= wr_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        stack_position <= stack_position_next;
        slice_position <= slice_position_next;
        band_second_half <= band_second_half_next;
        cap_phase <= cap_phase_next;
        vidx <= '0;
      end else if (load) begin
        vidx <= vidx + 1'b1;
      end
      if (load) begin
        vertex_valid <= 1'b1;
      end else if (vertex_valid && !vertex_stall) begin
        vertex_valid <= 1'b0;
      end
    end
  end

  uvs_divider #(
    .NUM_BITS (KBits),
    .DEN_BITS (COUNT_BITS),
    .FRAC_BITS(DivFrac)
  ) u_div_lat (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  ({1'b0, j_list[vidx]}),
    .den  (stacks),
    .busy (busy_j),
    .quot (quot_j)
  );

  uvs_divider #(
    .NUM_BITS (KBits),
    .DEN_BITS (COUNT_BITS),
    .FRAC_BITS(DivFrac)
  ) u_div_lng (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (k_list[vidx]),
    .den  (slices),
    .busy (busy_k),
    .quot (quot_k)
  );

  assign lat_ang = quot_j[DivFrac-ANGLE_BITS+1 +: ANGLE_BITS] + LatOffset;
  assign lng_ang = quot_k[DivFrac-ANGLE_BITS+1 +: ANGLE_BITS] + LngOffset;
  assign ang = feed_lng ? lng_ang : lat_ang;
  assign a32 = {ang, {(32-ANGLE_BITS){1'b0}}};

  assign chain[0].valid = feed_valid;
  assign chain[0].lng = feed_lng;
  assign chain[0].quad = quad_t'(a32[31:30]);
  assign chain[0].x = GAIN_Q30;
  assign chain[0].y = '0;
  assign chain[0].z = {2'b00, a32[29:0]};

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    uvs_cordic_cell #(
      .STEP(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .beat_in (chain[g]),
      .beat_out(chain[g+1])
    );
  end

  assign tail = chain[CORDIC_STEPS];

  always_comb begin
    case (tail.quad)
      QUAD_I:   begin c_map = tail.x;  s_map = tail.y;  end
      QUAD_II:  begin c_map = -tail.y; s_map = tail.x;  end
      QUAD_III: begin c_map = -tail.x; s_map = -tail.y; end
      default:  begin c_map = tail.y;  s_map = -tail.x; end
    endcase
  end

  assign prod_x = c_lat * s_lng;
  assign prod_z = c_lat * c_lng;
  assign rad_s = {1'b0, radius};

  always_ff @(posedge clk) begin
    if (accept) begin
      j_list <= j_tri;
      k_list <= k_tri;
      sphere_last <= tri_last;
    end
    if (tail.valid && !tail.lng) begin
      c_lat <= c_map;
      s_lat <= s_map;
    end
    if (tail.valid && tail.lng) begin
      c_lng <= c_map;
      s_lng <= s_map;
    end
    if (state == ST_MUL1) begin
      ux <= prod_x[61:30];
      uy <= s_lat;
      uz <= prod_z[61:30];
    end
    if (state == ST_MUL2) begin
      px <= ux * rad_s;
      py <= uy * rad_s;
      pz <= uz * rad_s;
    end
    if (load) begin
      pos_x <= sat_pos(px);
      pos_y <= sat_pos(py);
      pos_z <= sat_pos(pz);
      norm_x <= sat_norm(ux);
      norm_y <= sat_norm(uy);
      norm_z <= sat_norm(uz);
      tex_s <= quot_k[DivFrac-TEX_S_FRAC +: TEX_BITS];
      tex_t <= quot_j[DivFrac-TEX_T_FRAC +: TEX_BITS];
      triangle_end <= (vidx == LAST_VERTEX);
      sphere_end <= (vidx == LAST_VERTEX) && sphere_last;
    end
  end

  a_sphere_on_triangle: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && sphere_end |-> triangle_end)
    else $error("sphere end off a triangle end");

  a_tail_in_wait: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == ST_CORDIC) || (state == ST_FEED_LNG))
    else $error("chain beat outside the wait state");

  a_feed_after_div: assert property (@(posedge clk) disable iff (rst)
    feed_valid |-> !busy_j && !busy_k)
    else $error("chain fed while a division runs");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |=> vertex_valid)
    else $error("loaded vertex not shown");

endmodule
